// ----- rtl/kdp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the exp lookup table for the keyword detect post-processor.
package kdp_pkg;

   localparam int NUM_CLASSES     = 4;
   localparam int EXP_TABLE_DEPTH = 256;

   localparam int LOGIT_W    = 16;
   localparam int CLASS_W    = 2;
   localparam int CONF_W     = 16;
   localparam int MS_W       = 32;
   localparam int RUN_LEN_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   // exp table entries reach 65536 at index zero
   localparam int EXP_W      = 17;
   localparam int EXP_IDX_W  = $clog2(EXP_TABLE_DEPTH);
   localparam int D_FRAC_W   = 14;
   localparam int D_W        = LOGIT_W + 1;
   localparam int D_LIMIT    = 1 << D_FRAC_W;
   localparam int PROD_W     = D_FRAC_W + EXP_IDX_W;
   localparam int SUM_W      = $clog2(NUM_CLASSES * (1 << CONF_W) + 1);

   // 2^32 / sum with sum >= 2^16 leaves a quotient of at most 17 bits
   localparam int QUOT_W     = CONF_W + 1;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int REM_INIT   = 1 << (MS_W - QUOT_W);

   localparam logic [RUN_LEN_W-1:0] RUN_LEN_MAX = '1;
   localparam logic [CONF_W-1:0]    CONF_MAX    = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGREE_COUNT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNKNOWN_CLASS  = 2'd3;

   localparam logic [CONF_W-1:0]    CONF_THRESHOLD_RST = 16'd45875;
   localparam logic [MS_W-1:0]      DEBOUNCE_MS_RST    = 32'd1500;
   localparam logic [RUN_LEN_W-1:0] AGREE_COUNT_RST    = 4'd3;
   localparam logic [CLASS_W-1:0]   UNKNOWN_CLASS_RST  = 2'd3;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit_0;
      logic signed [LOGIT_W-1:0] logit_1;
      logic signed [LOGIT_W-1:0] logit_2;
      logic signed [LOGIT_W-1:0] logit_3;
      logic [MS_W-1:0]           now_ms;
   } req_data_type;

   typedef struct packed {
      logic [CLASS_W-1:0] detected_class;
      logic [CONF_W-1:0]  min_confidence;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAX,
      ST_SUM,
      ST_DIV,
      ST_DECIDE
   } kdp_state_type;

   typedef struct packed {
      logic             load;
      logic             max_step;
      logic             sum_step;
      logic             sum_first;
      logic             div_step;
      logic             div_first;
      logic             decide;
      logic [CNT_W-1:0] idx;
   } kdp_cmd_type;

   typedef struct packed {
      logic slot_free;
   } kdp_status_type;

   typedef logic [EXP_TABLE_DEPTH-1:0][EXP_W-1:0] exp_table_type;

   localparam logic [63:0] Q32_ONE  = 64'h1_0000_0000;
   localparam logic [63:0] Q32_MASK = 64'h0_FFFF_FFFF;

   // exp(-x) in Q32 for 0 <= x < 1, truncating Taylor series
   function automatic logic [63:0] exp_neg_frac(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      x    = x_in & Q32_MASK;
      term = Q32_ONE;
      pos  = Q32_ONE;
      neg  = '0;
      for (int n = 1; n <= 20; n++) begin
         term = ((term * x) >> 32) / 64'(n);
         if (n % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return pos - neg;
   endfunction

   function automatic logic [EXP_W-1:0] exp_entry(input int k, input logic [63:0] einv);
      logic [63:0] t;
      logic [63:0] ip;
      logic [63:0] val;
      t   = (64'(k) << 36) / EXP_TABLE_DEPTH;
      ip  = t >> 32;
      val = exp_neg_frac(t & Q32_MASK);
      for (int i = 0; i < int'(ip); i++) begin
         val = (val * einv) >> 32;
      end
      return EXP_W'((val + 64'd32768) >> 16);
   endfunction

   function automatic exp_table_type build_exp_table();
      logic [63:0]   h;
      logic [63:0]   einv;
      exp_table_type tbl;
      h    = exp_neg_frac(64'h8000_0000);
      einv = (h * h) >> 32;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         tbl[k] = exp_entry(k, einv);
      end
      return tbl;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

// ----- rtl/keyword_detect_postprocess.sv -----
`timescale 1ns / 1ps
// Top level of the keyword detect post-processor: sequencer plus datapath.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      req_data (4 logits, now_ms)
//   rsp      out        rsp_valid / rsp_stall      rsp_data (class, min confidence)
//   csr      in         csr_wr_en                  csr_index, csr_wdata
//
// One window at a time: an accept step, 3 argmax steps, 4 exp-table steps,
// 17 reciprocal steps (one quotient bit each) and 1 run update.
// The shift-subtract reciprocal makes up most of those steps.
// Reset is synchronous and restores register defaults and the run state.
// A held result only delays the run update step; the next window waits in req.
module keyword_detect_postprocess import kdp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   kdp_cmd_type    cmd;
   kdp_status_type status;

   kdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kdp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ----- rtl/kdp_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: steps one window through argmax, exp sum, reciprocal and run update.
module kdp_ctrl import kdp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  kdp_status_type status,
   output kdp_cmd_type    cmd
);

   kdp_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   localparam logic [CNT_W-1:0] LAST_CLASS = CNT_W'(NUM_CLASSES - 1);
   localparam logic [CNT_W-1:0] LAST_DIV   = CNT_W'(DIV_STEPS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MAX;
               cnt_in   = CNT_W'(1);
            end
         end
         ST_MAX: begin
            if (cnt_ff == LAST_CLASS) begin
               state_in = ST_SUM;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SUM: begin
            if (cnt_ff == LAST_CLASS) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV: begin
            if (cnt_ff == LAST_DIV) begin
               state_in = ST_DECIDE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DECIDE: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.idx       = cnt_ff;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MAX: begin
            cmd.max_step = 1'b1;
         end
         ST_SUM: begin
            cmd.sum_step  = 1'b1;
            cmd.sum_first = (cnt_ff == '0);
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
         end
         ST_DECIDE: begin
            cmd.decide = status.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   a_decide_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !status.slot_free) |=> state_ff == ST_DECIDE)
      else $error("decide step left while result slot still held");

   a_max_skips_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAX) |-> cnt_ff != '0)
      else $error("argmax step revisited class zero");

endmodule

// ----- rtl/kdp_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: window registers, argmax, exp sum, shift-subtract reciprocal, run state, CSRs.
module kdp_datapath import kdp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  kdp_cmd_type           cmd,
   output kdp_status_type        status,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [CONF_W-1:0]    conf_threshold_ff;
   logic [MS_W-1:0]      debounce_ms_ff;
   logic [RUN_LEN_W-1:0] agree_count_ff;
   logic [CLASS_W-1:0]   unknown_class_ff;

   // window and working registers
   logic signed [LOGIT_W-1:0] logit_ff [NUM_CLASSES];
   logic [MS_W-1:0]           now_ff;
   logic signed [LOGIT_W-1:0] max_ff, max_in;
   logic [CLASS_W-1:0]        cls_ff, cls_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [SUM_W-1:0]          rem_ff, rem_in;
   logic [QUOT_W-1:0]         quot_ff, quot_in;

   // run state
   logic [CLASS_W-1:0]   run_class_ff, run_class_in;
   logic [RUN_LEN_W-1:0] run_len_ff, run_len_in;
   logic [CONF_W-1:0]    run_min_ff, run_min_in;
   logic [MS_W-1:0]      last_fire_ff, last_fire_in;
   logic                 has_fired_ff, has_fired_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   // per-step signals
   logic signed [LOGIT_W-1:0] logit_sel;
   logic [D_W-1:0]            diff;
   logic [PROD_W-1:0]         prod;
   logic [EXP_IDX_W-1:0]      exp_idx;
   logic [EXP_W-1:0]          exp_term;
   logic [SUM_W-1:0]          sum_base;
   logic [SUM_W-1:0]          rem_base;
   logic [SUM_W:0]            trial;
   logic                      q_bit;
   logic [CONF_W-1:0]         conf;
   logic                      reject;
   logic                      extend;
   logic [RUN_LEN_W-1:0]      new_len;
   logic [CONF_W-1:0]         new_min;
   logic [MS_W-1:0]           since_fire;
   logic                      fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= CONF_THRESHOLD_RST;
         debounce_ms_ff    <= DEBOUNCE_MS_RST;
         agree_count_ff    <= AGREE_COUNT_RST;
         unknown_class_ff  <= UNKNOWN_CLASS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CONF_THRESHOLD: conf_threshold_ff <= csr_wdata[CONF_W-1:0];
            CSR_DEBOUNCE_MS:    debounce_ms_ff    <= csr_wdata[MS_W-1:0];
            CSR_AGREE_COUNT:    agree_count_ff    <= csr_wdata[RUN_LEN_W-1:0];
            CSR_UNKNOWN_CLASS:  unknown_class_ff  <= csr_wdata[CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         logit_ff[0] <= req_data.logit_0;
         logit_ff[1] <= req_data.logit_1;
         logit_ff[2] <= req_data.logit_2;
         logit_ff[3] <= req_data.logit_3;
         now_ff      <= req_data.now_ms;
      end
   end

   assign logit_sel = logit_ff[cmd.idx[CLASS_W-1:0]];

   // argmax, lowest index wins ties
   always_comb begin
      max_in = max_ff;
      cls_in = cls_ff;
      if (cmd.load) begin
         max_in = req_data.logit_0;
         cls_in = '0;
      end else if (cmd.max_step && (logit_sel > max_ff)) begin
         max_in = logit_sel;
         cls_in = cmd.idx[CLASS_W-1:0];
      end
   end

   // exp term for one class; differences of 16.0 or more contribute nothing
   assign diff     = {max_ff[LOGIT_W-1], max_ff} - {logit_sel[LOGIT_W-1], logit_sel};
   assign prod     = PROD_W'(diff[D_FRAC_W-1:0]) * PROD_W'(EXP_TABLE_DEPTH);
   assign exp_idx  = prod[PROD_W-1:D_FRAC_W];
   assign exp_term = (diff < D_W'(D_LIMIT)) ? EXP_TABLE[exp_idx] : '0;
   assign sum_base = cmd.sum_first ? '0 : sum_ff;

   always_comb begin
      sum_in = sum_ff;
      if (cmd.sum_step) begin
         sum_in = sum_base + SUM_W'(exp_term);
      end
   end

   // restoring division of 2^32 by the sum, one quotient bit a step
   assign rem_base = cmd.div_first ? SUM_W'(REM_INIT) : rem_ff;
   assign trial    = {rem_base, 1'b0};
   assign q_bit    = (trial >= {1'b0, sum_ff});

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.div_step) begin
         rem_in  = q_bit ? SUM_W'(trial - {1'b0, sum_ff}) : trial[SUM_W-1:0];
         quot_in = cmd.div_first ? QUOT_W'(q_bit) : {quot_ff[QUOT_W-2:0], q_bit};
      end
   end

   always_ff @(posedge clock) begin
      max_ff  <= max_in;
      cls_ff  <= cls_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign conf = quot_ff[QUOT_W-1] ? CONF_MAX : quot_ff[CONF_W-1:0];

   // run update and debounce
   assign reject     = (cls_ff == unknown_class_ff) || (conf < conf_threshold_ff);
   assign extend     = (cls_ff == run_class_ff) && (run_len_ff != '0);
   assign since_fire = now_ff - last_fire_ff;

   always_comb begin
      if (extend) begin
         new_len = (run_len_ff == RUN_LEN_MAX) ? run_len_ff : run_len_ff + RUN_LEN_W'(1);
         new_min = (conf < run_min_ff) ? conf : run_min_ff;
      end else begin
         new_len = RUN_LEN_W'(1);
         new_min = conf;
      end
   end

   assign fire = !reject && (new_len >= agree_count_ff)
                 && !(has_fired_ff && (since_fire < debounce_ms_ff));

   always_comb begin
      run_class_in = run_class_ff;
      run_len_in   = run_len_ff;
      run_min_in   = run_min_ff;
      last_fire_in = last_fire_ff;
      has_fired_in = has_fired_ff;
      if (cmd.decide) begin
         if (reject) begin
            run_class_in = unknown_class_ff;
            run_len_in   = '0;
         end else begin
            run_class_in = cls_ff;
            run_len_in   = fire ? '0 : new_len;
            run_min_in   = new_min;
            if (fire) begin
               last_fire_in = now_ff;
               has_fired_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff <= UNKNOWN_CLASS_RST;
         run_len_ff   <= '0;
         run_min_ff   <= '0;
         last_fire_ff <= '0;
         has_fired_ff <= 1'b0;
      end else begin
         run_class_ff <= run_class_in;
         run_len_ff   <= run_len_in;
         run_min_ff   <= run_min_in;
         last_fire_ff <= last_fire_in;
         has_fired_ff <= has_fired_in;
      end
   end

   // result slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.decide && fire) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.detected_class = cls_ff;
         rsp_data_in.min_confidence = new_min;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;

   a_fire_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && fire) |=> rsp_valid_ff)
      else $error("detection did not reach the result slot");

   a_fire_restarts: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && fire) |=> (run_len_ff == '0 && has_fired_ff))
      else $error("run not restarted after detection");

   a_decide_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> (!rsp_valid_ff || !rsp_stall))
      else $error("run update while result slot is blocked");

endmodule

// ----- tb/sv/keyword_detect_postprocess_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the keyword detect post-processor: scored against a softmax/run predictor.
module keyword_detect_postprocess_tb import kdp_pkg::*;;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_data_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_data_type          rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   keyword_detect_postprocess dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers
   logic [CONF_W-1:0]    cfg_conf_threshold;
   logic [MS_W-1:0]      cfg_debounce_ms;
   logic [RUN_LEN_W-1:0] cfg_agree_count;
   logic [CLASS_W-1:0]   cfg_unknown_class;

   // predictor copy of the run state
   logic [CLASS_W-1:0]   run_cls;
   logic [RUN_LEN_W-1:0] run_len;
   logic [CONF_W-1:0]    run_low_conf;
   logic [MS_W-1:0]      last_detect_ms;
   logic                 detect_seen;

   logic [EXP_W-1:0]     exp_weight [EXP_TABLE_DEPTH];
   rsp_data_type         expected_detections [$];
   rsp_data_type         oldest_detection;
   int                   mismatch_count;
   logic                 req_gaps_on;
   logic                 rsp_stalls_on;
   logic [MS_W-1:0]      stamp_ms;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // exp(-x) in Q32 for a Q32 fraction, truncating Taylor series
   function automatic logic [63:0] taylor_exp_neg(input logic [63:0] frac);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] plus;
      logic [63:0] minus;
      x     = frac & 64'hFFFF_FFFF;
      term  = 64'h1_0000_0000;
      plus  = term;
      minus = '0;
      for (int n = 1; n <= 20; n++) begin
         term = ((term * x) >> 32) / 64'(n);
         if (n % 2 == 1) begin
            minus = minus + term;
         end else begin
            plus = plus + term;
         end
      end
      return plus - minus;
   endfunction

   initial begin : exp_lut
      logic [63:0] half_e;
      logic [63:0] e_inv;
      logic [63:0] t;
      logic [63:0] v;
      half_e = taylor_exp_neg(64'h8000_0000);
      e_inv  = (half_e * half_e) >> 32;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         t = (64'(k) << 36) / 64'(EXP_TABLE_DEPTH);
         v = taylor_exp_neg(t);
         for (int i = 0; i < int'(t >> 32); i++) begin
            v = (v * e_inv) >> 32;
         end
         exp_weight[k] = EXP_W'((v + 64'd32768) >> 16);
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic predict_detection(input req_data_type w);
      int           lg [NUM_CLASSES];
      int           peak;
      int           d;
      int           sum;
      logic [1:0]   cls;
      logic [63:0]  quot;
      logic [15:0]  conf;
      rsp_data_type hit;
      lg[0] = $signed(w.logit_0);
      lg[1] = $signed(w.logit_1);
      lg[2] = $signed(w.logit_2);
      lg[3] = $signed(w.logit_3);
      peak  = lg[0];
      cls   = '0;
      for (int i = 1; i < NUM_CLASSES; i++) begin
         if (lg[i] > peak) begin
            peak = lg[i];
            cls  = CLASS_W'(i);
         end
      end
      sum = 0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         d = peak - lg[i];
         if (d < 16384) begin
            sum += int'(exp_weight[(d * EXP_TABLE_DEPTH) >> 14]);
         end
      end
      if (sum == 0) begin
         sum = 1;
      end
      quot = 64'h1_0000_0000 / 64'(sum);
      conf = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];

      if (cls == cfg_unknown_class || conf < cfg_conf_threshold) begin
         run_cls = cfg_unknown_class;
         run_len = '0;
      end else begin
         if (cls == run_cls && run_len != 0) begin
            if (run_len != RUN_LEN_MAX) begin
               run_len = run_len + 1'b1;
            end
            if (conf < run_low_conf) begin
               run_low_conf = conf;
            end
         end else begin
            run_cls      = cls;
            run_len      = 4'd1;
            run_low_conf = conf;
         end
         // wrapping difference decides the debounce
         if (run_len >= cfg_agree_count &&
             !(detect_seen && MS_W'(w.now_ms - last_detect_ms) < cfg_debounce_ms)) begin
            last_detect_ms     = w.now_ms;
            detect_seen        = 1'b1;
            run_len            = '0;
            hit.detected_class = cls;
            hit.min_confidence = run_low_conf;
            expected_detections.push_back(hit);
         end
      end
   endtask

   // score result beats, then predict from accepted request beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_detections.size() == 0) begin
            flag_mismatch($sformatf("unexpected detection: class %0d conf %0d",
                                    rsp_data.detected_class, rsp_data.min_confidence));
         end else begin
            oldest_detection = expected_detections.pop_front();
            if (rsp_data.detected_class !== oldest_detection.detected_class) begin
               flag_mismatch($sformatf("detected_class: want %0d got %0d",
                                       oldest_detection.detected_class,
                                       rsp_data.detected_class));
            end
            if (rsp_data.min_confidence !== oldest_detection.min_confidence) begin
               flag_mismatch($sformatf("min_confidence: want %0d got %0d",
                                       oldest_detection.min_confidence,
                                       rsp_data.min_confidence));
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         predict_detection(req_data);
      end
   end

   always @(negedge clock) begin
      rsp_stall <= rsp_stalls_on && ($urandom_range(0, 99) < 7);
   end

   function automatic req_data_type make_window(input int l0, input int l1, input int l2,
                                                input int l3, input logic [31:0] now);
      req_data_type w;
      w.logit_0 = 16'(l0);
      w.logit_1 = 16'(l1);
      w.logit_2 = 16'(l2);
      w.logit_3 = 16'(l3);
      w.now_ms  = now;
      return w;
   endfunction

   // class cls on top, the others trail it by gap_lo..gap_hi
   function automatic req_data_type shaped_window(input int cls, input int gap_lo,
                                                  input int gap_hi, input logic [31:0] now);
      int lg [NUM_CLASSES];
      int top;
      top = int'($urandom_range(65535, gap_hi)) - 32768;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         lg[i] = (i == cls) ? top : top - int'($urandom_range(gap_hi, gap_lo));
      end
      return make_window(lg[0], lg[1], lg[2], lg[3], now);
   endfunction

   task automatic send_window(input req_data_type w);
      @(negedge clock);
      while (req_gaps_on && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // stop sending, let every pending detection arrive and the last window finish
   task automatic settle_detections();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_detections.size() != 0) begin
         @(negedge clock);
      end
      repeat (64) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_CONF_THRESHOLD: cfg_conf_threshold = data[CONF_W-1:0];
         CSR_DEBOUNCE_MS:    cfg_debounce_ms    = data[MS_W-1:0];
         CSR_AGREE_COUNT:    cfg_agree_count    = data[RUN_LEN_W-1:0];
         CSR_UNKNOWN_CLASS:  cfg_unknown_class  = data[CLASS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CONF_W-1:0] thr, input logic [MS_W-1:0] deb,
                                 input logic [RUN_LEN_W-1:0] agr,
                                 input logic [CLASS_W-1:0] unk);
      settle_detections();
      write_csr(CSR_CONF_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(CSR_DEBOUNCE_MS, CSR_DATA_W'(deb));
      write_csr(CSR_AGREE_COUNT, CSR_DATA_W'(agr));
      write_csr(CSR_UNKNOWN_CLASS, CSR_DATA_W'(unk));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_field_extremes();
      send_window(make_window(-32768, -32768, -32768, -32768, 32'd0));
      send_window(make_window(32767, 32767, 32767, 32767, 32'hFFFF_FFFF));
      send_window(make_window(-32768, -32768, -32768, 32767, 32'd5));
      send_window(make_window(32767, -32768, -32768, -32768, 32'h8000_0000));
   endtask

   // first detection is never held off; min confidence tracks across the run
   task automatic test_first_detection();
      send_window(make_window(-3000, -4000, 2000, -6000, 32'd100));
      send_window(make_window(-1000, -5500, 3000, -9000, 32'd200));
      send_window(make_window(-20000, 1000, 4000, -20000, 32'd300));
   endtask

   // a run that has reached the agree count retries on each window until the debounce has passed
   task automatic test_debounce_retry();
      send_window(make_window(-9000, -8000, 5000, 0, 32'd700));
      send_window(make_window(-9000, -8000, 5000, 1000, 32'd1000));
      send_window(make_window(-32768, 0, 9000, 2000, 32'd1799));
      send_window(make_window(-9000, 0, 6000, -32768, 32'd1800));
   endtask

   task automatic test_ties_open_settings();
      apply_settings('0, '0, 4'd1, 2'd0);
      send_window(make_window(500, 500, 500, 500, 32'd10));
      send_window(make_window(-100, 2000, 2000, 0, 32'd10));
      send_window(make_window(-100, 2000, 2000, 0, 32'd10));
      send_window(make_window(-32768, 3, 3, 3, 32'd12));
   endtask

   task automatic test_agree_zero();
      apply_settings(CONF_THRESHOLD_RST, '0, 4'd0, UNKNOWN_CLASS_RST);
      send_window(make_window(30000, -30000, -30000, -30000, 32'd20));
   endtask

   // with an all-ones debounce only a difference of all ones gets through
   task automatic test_strict_settings();
      logic [MS_W-1:0] base;
      apply_settings(CONF_MAX, 32'hFFFF_FFFF, 4'd2, UNKNOWN_CLASS_RST);
      base = last_detect_ms;
      send_window(make_window(32767, -32768, -32768, -32768, base));
      send_window(make_window(32767, -32768, -32768, -32768, base));
      send_window(make_window(32767, -32768, -32768, -32768, base - 1'b1));
      send_window(make_window(32767, 27767, -32768, -32768, base + 1'b1));
   endtask

   task automatic test_random_traffic();
      logic [CONF_W-1:0]    thr;
      logic [MS_W-1:0]      deb;
      logic [RUN_LEN_W-1:0] agr;
      int                   sent;
      int                   cls;
      int                   len;
      int                   gap_lo;
      int                   gap_hi;
      int                   pick;
      for (int ph = 0; ph < 13; ph++) begin
         case (ph)
            0: apply_settings(CONF_THRESHOLD_RST, DEBOUNCE_MS_RST, AGREE_COUNT_RST,
                              UNKNOWN_CLASS_RST);
            1: apply_settings(16'd40000, '0, 4'd15, 2'd1);
            2: apply_settings(CONF_MAX, '0, 4'd2, 2'd0);
            3: apply_settings(16'd30000, 32'hFFFF_FFFF, 4'd1, 2'd2);
            default: begin
               pick = $urandom_range(0, 5);
               thr  = (pick == 0) ? '0 : (pick == 1) ? CONF_MAX :
                      CONF_W'($urandom_range(65535, 30000));
               pick = $urandom_range(0, 5);
               deb  = (pick == 0) ? '0 : (pick == 1) ? 32'hFFFF_FFFF :
                      MS_W'($urandom_range(4000, 0));
               agr  = ($urandom_range(0, 3) == 0) ? RUN_LEN_W'($urandom_range(15, 0)) :
                      RUN_LEN_W'($urandom_range(4, 1));
               apply_settings(thr, deb, agr, CLASS_W'($urandom_range(3, 0)));
            end
         endcase
         // one phase runs flat out on both sides
         req_gaps_on   = (ph != 4);
         rsp_stalls_on = (ph != 4);
         if (ph == 5) begin
            stamp_ms = 32'hFFFF_F800;
         end
         sent = 0;
         while (sent < 100) begin
            if ($urandom_range(0, 99) < 15) begin
               send_window(req_data_type'({$urandom, $urandom, $urandom}));
               sent++;
            end else begin
               cls  = $urandom_range(0, 3);
               len  = $urandom_range(1, ((cfg_agree_count == 0) ? 1 : cfg_agree_count) + 4);
               pick = $urandom_range(0, 99);
               if (pick < 45) begin
                  gap_lo = 4000;
                  gap_hi = 40000;
               end else if (pick < 85) begin
                  gap_lo = 300;
                  gap_hi = 8000;
               end else begin
                  gap_lo = 0;
                  gap_hi = 2500;
               end
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 49) == 0) begin
                     stamp_ms = stamp_ms + $urandom;
                  end else begin
                     stamp_ms = stamp_ms + MS_W'($urandom_range(900, 0));
                  end
                  send_window(shaped_window(cls, gap_lo, gap_hi, stamp_ms));
                  sent++;
               end
            end
         end
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      rsp_stall          = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_gaps_on        = 1'b1;
      rsp_stalls_on      = 1'b1;
      mismatch_count     = 0;
      stamp_ms           = '0;
      cfg_conf_threshold = CONF_THRESHOLD_RST;
      cfg_debounce_ms    = DEBOUNCE_MS_RST;
      cfg_agree_count    = AGREE_COUNT_RST;
      cfg_unknown_class  = UNKNOWN_CLASS_RST;
      run_cls            = UNKNOWN_CLASS_RST;
      run_len            = '0;
      run_low_conf       = '0;
      last_detect_ms     = '0;
      detect_seen        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_first_detection();
      test_debounce_retry();
      test_ties_open_settings();
      test_agree_zero();
      test_strict_settings();
      test_random_traffic();

      settle_detections();
      if (mismatch_count == 0 && expected_detections.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
